// ===== sv/lc3x_pkg.sv =====
// shared types, codes and helpers of the lc3 subset execute core
package lc3x_pkg;

  // default memory address width (words = 2**bits)
  localparam int unsigned MEM_ADDR_BITS_DEF = 16;

  // decoupling queue between the decode and execute sides
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // request kinds on the input channel
  localparam logic [1:0] REQ_EXEC = 2'd0;
  localparam logic [1:0] REQ_MEM  = 2'd1;
  localparam logic [1:0] REQ_REG  = 2'd2;

  // register preload targets above the general registers
  localparam logic [3:0] SEL_PC = 4'd8;
  localparam logic [3:0] SEL_CC = 4'd9;

  // opcodes in bits 15..12
  localparam logic [3:0] OP_BR  = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_ST  = 4'd3;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_LDR = 4'd6;
  localparam logic [3:0] OP_STR = 4'd7;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_LDI = 4'd10;
  localparam logic [3:0] OP_STI = 4'd11;
  localparam logic [3:0] OP_LEA = 4'd14;

  // condition codes
  localparam logic [2:0] CC_N = 3'b100;
  localparam logic [2:0] CC_Z = 3'b010;
  localparam logic [2:0] CC_P = 3'b001;

  // what the execute side has to do with a word
  typedef enum logic [3:0] {
    K_ADD,
    K_AND,
    K_NOT,
    K_LEA,
    K_LD,
    K_LDI,
    K_LDR,
    K_ST,
    K_STI,
    K_STR,
    K_BR,
    K_MEMLD,
    K_REGLD,
    K_PCLD,
    K_CCLD,
    K_BAD
  } kind_t;

  // decoded word handed from front to back
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  r1;       // destination, store source or nzp mask
    logic [2:0]  r2;       // base or first source
    logic [2:0]  r3;       // second source register
    logic        use_imm;
    logic [15:0] imm;      // sign-extended immediate or offset
    logic [15:0] addr;     // preload address
    logic [15:0] value;    // preload value
  } op_t;

  // execute side sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD1,
    ST_RD2,
    ST_OUT
  } state_t;

  // n, z or p from a written value
  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] r;
    if (v == 16'd0) begin
      r = CC_Z;
    end else if (v[15]) begin
      r = CC_N;
    end else begin
      r = CC_P;
    end
    return r;
  endfunction

endpackage

// ===== sv/lc3x_ifs.sv =====
// valid/ready channel interfaces for requests and responses
interface lc3x_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [15:0] instr_word;
  logic [15:0] load_address;
  logic [15:0] load_value;
  logic [3:0]  reg_select;

  modport source (
    output valid, req_type, instr_word, load_address, load_value, reg_select,
    input  ready
  );
  modport sink (
    input  valid, req_type, instr_word, load_address, load_value, reg_select,
    output ready
  );
endinterface

interface lc3x_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] dest_value;
  logic [2:0]  cond_code;
  logic [15:0] pc_value;
  logic        mem_written;
  logic        status;

  modport source (
    output valid, dest_value, cond_code, pc_value, mem_written, status,
    input  ready
  );
  modport sink (
    input  valid, dest_value, cond_code, pc_value, mem_written, status,
    output ready
  );
endinterface

// ===== sv/lc3x_front.sv =====
// front side: accepts request words and decodes them into queue entries
module lc3x_front (
  lc3x_req_if.sink     req,
  input  logic         full,
  output logic         push,
  output lc3x_pkg::op_t push_data
);
  import lc3x_pkg::*;

  logic [3:0]  opc;
  logic [15:0] imm5;
  logic [15:0] off6;
  logic [15:0] off9;

  // take a word whenever the queue has room
  assign req.ready = !full;
  assign push      = req.valid && !full;

  // immediate fields
  assign opc  = req.instr_word[15:12];
  assign imm5 = {{11{req.instr_word[4]}}, req.instr_word[4:0]};
  assign off6 = {{10{req.instr_word[5]}}, req.instr_word[5:0]};
  assign off9 = {{7{req.instr_word[8]}}, req.instr_word[8:0]};

  // classify the word
  always_comb begin
    push_data.r1      = req.instr_word[11:9];
    push_data.r2      = req.instr_word[8:6];
    push_data.r3      = req.instr_word[2:0];
    push_data.use_imm = req.instr_word[5];
    push_data.imm     = off9;
    push_data.addr    = req.load_address;
    push_data.value   = req.load_value;
    push_data.kind    = K_BAD;
    unique case (req.req_type)
      REQ_EXEC: begin
        unique case (opc)
          OP_ADD: begin
            push_data.kind = K_ADD;
            push_data.imm  = imm5;
          end
          OP_AND: begin
            push_data.kind = K_AND;
            push_data.imm  = imm5;
          end
          OP_NOT: push_data.kind = K_NOT;
          OP_LEA: push_data.kind = K_LEA;
          OP_LD:  push_data.kind = K_LD;
          OP_LDI: push_data.kind = K_LDI;
          OP_LDR: begin
            push_data.kind = K_LDR;
            push_data.imm  = off6;
          end
          OP_ST:  push_data.kind = K_ST;
          OP_STI: push_data.kind = K_STI;
          OP_STR: begin
            push_data.kind = K_STR;
            push_data.imm  = off6;
          end
          OP_BR:  push_data.kind = K_BR;
          default: push_data.kind = K_BAD;
        endcase
      end
      REQ_MEM: push_data.kind = K_MEMLD;
      REQ_REG: begin
        if (!req.reg_select[3]) begin
          push_data.kind = K_REGLD;
          push_data.r1   = req.reg_select[2:0];
        end else if (req.reg_select == SEL_PC) begin
          push_data.kind = K_PCLD;
        end else if (req.reg_select == SEL_CC) begin
          // only the three flag bits survive
          push_data.kind  = K_CCLD;
          push_data.value = {13'd0, req.load_value[2:0]};
        end else begin
          push_data.kind = K_BAD;
        end
      end
      default: push_data.kind = K_BAD;
    endcase
  end

endmodule

// ===== sv/lc3x_queue.sv =====
// short fifo of decoded words between front and back
module lc3x_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lc3x_pkg::op_t push_data,
  output logic          full,
  input  logic          pop,
  output lc3x_pkg::op_t pop_data,
  output logic          empty
);
  import lc3x_pkg::*;

  op_t               slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full     = (count == QCNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/lc3x_back.sv =====
// back side: register file, pc, flags, word memory and response register
module lc3x_back #(
  parameter int unsigned MEM_ADDR_BITS = lc3x_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          empty,
  output logic          pop,
  input  lc3x_pkg::op_t pop_data,
  lc3x_rsp_if.source    rsp
);
  import lc3x_pkg::*;

  localparam int unsigned MEM_WORDS = 1 << MEM_ADDR_BITS;

  state_t state;
  state_t state_next;
  op_t    cur;

  logic [15:0] gpr [8];
  logic [15:0] pc;
  logic [2:0]  cc;

  logic [15:0] mem [MEM_WORDS];
  logic                     rd_en;
  logic [MEM_ADDR_BITS-1:0] rd_addr;
  logic [15:0]              rd_data;
  logic                     wr_en;
  logic [MEM_ADDR_BITS-1:0] wr_addr;
  logic [15:0]              wr_data;

  logic        rf_we;
  logic [2:0]  rf_idx;
  logic [15:0] rf_data;
  logic        cc_we;
  logic [2:0]  cc_data;
  logic        pc_we;
  logic [15:0] pc_data;

  logic        res_ld;
  logic [15:0] res_dval;
  logic [15:0] res_dval_next;
  logic        res_mw;
  logic        res_mw_next;
  logic        res_st;
  logic        res_st_next;

  logic        out_ld;
  logic        rsp_valid;

  logic [15:0] base;
  logic [15:0] ea;
  logic [15:0] src_b;
  logic [15:0] alu;

  // effective address and second operand
  assign base  = (cur.kind == K_LDR || cur.kind == K_STR) ? gpr[cur.r2] : pc;
  assign ea    = base + cur.imm;
  assign src_b = cur.use_imm ? cur.imm : gpr[cur.r3];
  assign alu   = (cur.kind == K_ADD) ? (gpr[cur.r2] + src_b) : (gpr[cur.r2] & src_b);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state and datapath controls
  always_comb begin
    state_next    = state;
    pop           = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = ea[MEM_ADDR_BITS-1:0];
    wr_en         = 1'b0;
    wr_addr       = ea[MEM_ADDR_BITS-1:0];
    wr_data       = gpr[cur.r1];
    rf_we         = 1'b0;
    rf_idx        = cur.r1;
    rf_data       = rd_data;
    cc_we         = 1'b0;
    cc_data       = cc_of(rd_data);
    pc_we         = 1'b0;
    pc_data       = ea;
    res_ld        = 1'b0;
    res_dval_next = 16'd0;
    res_mw_next   = 1'b0;
    res_st_next   = 1'b0;
    out_ld        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!empty) begin
          pop        = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_ld     = 1'b1;
        state_next = ST_OUT;
        unique case (cur.kind)
          K_ADD, K_AND: begin
            rf_we         = 1'b1;
            rf_data       = alu;
            cc_we         = 1'b1;
            cc_data       = cc_of(alu);
            res_dval_next = alu;
          end
          K_NOT: begin
            rf_we         = 1'b1;
            rf_data       = ~gpr[cur.r2];
            cc_we         = 1'b1;
            cc_data       = cc_of(~gpr[cur.r2]);
            res_dval_next = ~gpr[cur.r2];
          end
          K_LEA: begin
            rf_we         = 1'b1;
            rf_data       = ea;
            res_dval_next = ea;
          end
          K_LD, K_LDI, K_LDR, K_STI: begin
            // first memory read, result comes later
            res_ld     = 1'b0;
            rd_en      = 1'b1;
            state_next = ST_RD1;
          end
          K_ST, K_STR: begin
            wr_en         = 1'b1;
            res_dval_next = gpr[cur.r1];
            res_mw_next   = 1'b1;
          end
          K_BR: begin
            pc_we = ((cur.r1 & cc) != 3'd0);
          end
          K_MEMLD: begin
            wr_en         = 1'b1;
            wr_addr       = cur.addr[MEM_ADDR_BITS-1:0];
            wr_data       = cur.value;
            res_dval_next = cur.value;
            res_mw_next   = 1'b1;
          end
          K_REGLD: begin
            rf_we         = 1'b1;
            rf_data       = cur.value;
            res_dval_next = cur.value;
          end
          K_PCLD: begin
            pc_we         = 1'b1;
            pc_data       = cur.value;
            res_dval_next = cur.value;
          end
          K_CCLD: begin
            cc_we         = 1'b1;
            cc_data       = cur.value[2:0];
            res_dval_next = cur.value;
          end
          K_BAD: begin
            res_st_next = 1'b1;
          end
          default: begin
            res_st_next = 1'b1;
          end
        endcase
      end
      ST_RD1: begin
        if (cur.kind == K_LDI) begin
          // pointer read back, fetch the operand it points at
          rd_en      = 1'b1;
          rd_addr    = rd_data[MEM_ADDR_BITS-1:0];
          state_next = ST_RD2;
        end else if (cur.kind == K_STI) begin
          wr_en         = 1'b1;
          wr_addr       = rd_data[MEM_ADDR_BITS-1:0];
          res_ld        = 1'b1;
          res_dval_next = gpr[cur.r1];
          res_mw_next   = 1'b1;
          state_next    = ST_OUT;
        end else begin
          rf_we         = 1'b1;
          cc_we         = 1'b1;
          res_ld        = 1'b1;
          res_dval_next = rd_data;
          state_next    = ST_OUT;
        end
      end
      ST_RD2: begin
        rf_we         = 1'b1;
        cc_we         = 1'b1;
        res_ld        = 1'b1;
        res_dval_next = rd_data;
        state_next    = ST_OUT;
      end
      ST_OUT: begin
        if (!rsp_valid || rsp.ready) begin
          out_ld     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // current word
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  // architectural registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        gpr[i] <= 16'd0;
      end
      pc <= 16'd0;
      cc <= CC_Z;
    end else begin
      if (rf_we) begin
        gpr[rf_idx] <= rf_data;
      end
      if (pc_we) begin
        pc <= pc_data;
      end
      if (cc_we) begin
        cc <= cc_data;
      end
    end
  end

  // word memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // step result held until the response slot is free
  always_ff @(posedge clk) begin
    if (res_ld) begin
      res_dval <= res_dval_next;
      res_mw   <= res_mw_next;
      res_st   <= res_st_next;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_ld) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      rsp.dest_value  <= res_dval;
      rsp.cond_code   <= cc;
      rsp.pc_value    <= pc;
      rsp.mem_written <= res_mw;
      rsp.status      <= res_st;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

// ===== sv/lc3_subset_execute_core.sv =====
// top level of the lc3 subset execute core
//
//   channel  modport  direction  payload
//   req      sink     in         req_type, instr_word, load_address, load_value, reg_select
//   rsp      source   out        dest_value, cond_code, pc_value, mem_written, status
//
// one word at a time in the back: alu, lea, br, st, str and preloads pass idle, exec, out;
// ld, ldr and sti add rd1, ldi adds rd1 and rd2; these states serve the single synchronous
// read port of the word memory, used once per dependent read
// a two-entry queue after decode keeps req taking words while the back works or rsp stalls
// synchronous reset clears registers, pc and the queue and sets the flags to z;
// the word memory is not cleared and holds no defined value until written
module lc3_subset_execute_core #(
  parameter int unsigned MEM_ADDR_BITS = lc3x_pkg::MEM_ADDR_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lc3x_req_if.sink   req,
  lc3x_rsp_if.source rsp
);
  import lc3x_pkg::*;

  logic push;
  logic full;
  logic pop;
  logic empty;
  op_t  push_data;
  op_t  pop_data;

  // decode
  lc3x_front u_front (
    .req       (req),
    .full      (full),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue
  lc3x_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // execute
  lc3x_back #(
    .MEM_ADDR_BITS (MEM_ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop      (pop),
    .pop_data (pop_data),
    .rsp      (rsp)
  );

endmodule

// ===== sv/lc3x_checker.sv =====
// port-level checks on the execute core, bound to the top level
module lc3x_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] rsp_dest_value,
  input logic [2:0]  rsp_cond_code,
  input logic [15:0] rsp_pc_value,
  input logic        rsp_mem_written,
  input logic        rsp_status
);

  logic [2:0] pending;
  logic       req_acc;
  logic       rsp_acc;

  assign req_acc = req_valid && req_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  // words taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 3'd0;
    end else begin
      pending <= pending + {2'd0, req_acc} - {2'd0, rsp_acc};
    end
  end

  // stalled response holds its word
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dest_value) &&
      $stable(rsp_cond_code) && $stable(rsp_pc_value) &&
      $stable(rsp_mem_written) && $stable(rsp_status))
    else $error("response changed while stalled");

  // nothing answered right after reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

  // every response belongs to an accepted word
  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 3'd0)
    else $error("response without a request");

  // an ignored word writes nothing
  a_ignored: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status |-> rsp_dest_value == 16'd0 && !rsp_mem_written)
    else $error("ignored word reported a write");

endmodule

bind lc3_subset_execute_core lc3x_checker u_lc3x_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_dest_value  (rsp.dest_value),
  .rsp_cond_code   (rsp.cond_code),
  .rsp_pc_value    (rsp.pc_value),
  .rsp_mem_written (rsp.mem_written),
  .rsp_status      (rsp.status)
);
